// ===== hdl/sapq_pkg.sv =====
`default_nettype none

package sapq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int KEY_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [KEY_W-1:0]         key;
  } entry_t;

  // broadcast from the control logic to all cells
  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sapq_if.sv =====
`default_nettype none

interface sapq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [sapq_pkg::DATA_W-1:0]  item_data;
  logic [sapq_pkg::KEY_W-1:0]          priority_key;

  modport source (output valid, command, item_data, priority_key, input ready);
  modport sink   (input valid, command, item_data, priority_key, output ready);
endinterface

interface sapq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sapq_pkg::DATA_W-1:0]  out_data;
  logic [sapq_pkg::KEY_W-1:0]          out_key;
  logic [sapq_pkg::STATUS_W-1:0]       status;
  logic [sapq_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, out_data, out_key, status, occupancy, input ready);
  modport sink   (input valid, out_data, out_key, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== hdl/sapq_cell.sv =====
`default_nettype none

module sapq_cell (
  input  wire logic               clk,
  input  wire sapq_pkg::cell_ctl_t ctl,
  input  wire logic               valid,
  input  wire sapq_pkg::entry_t   left_entry,
  input  wire logic               left_disp,
  input  wire sapq_pkg::entry_t   right_entry,
  output sapq_pkg::entry_t        entry,
  output logic                    disp
);

  sapq_pkg::entry_t entry_r;
  sapq_pkg::entry_t entry_nxt;

  // displaced: empty, or holding a strictly larger key (ties stay ahead)
  assign disp  = !valid || (entry_r.key > ctl.new_entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      sapq_pkg::OP_INSERT: begin
        if (disp) begin
          entry_nxt = left_disp ? left_entry : ctl.new_entry;
        end
      end
      sapq_pkg::OP_REMOVE: entry_nxt = right_entry;
      default:             entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_array_priority_queue.sv =====
`default_nettype none

// Channel  | Dir | Handshake             | Payload
// in_ch    | in  | valid/ready           | command, item_data, priority_key
// out_ch   | out | valid/ready           | out_data, out_key, status, occupancy
//
// One item per cycle while in_ch.ready is high: every cell compares and shifts
// in parallel, and the result is registered and shown in the next cycle.
// The result register frees in the cycle it is taken, so in_ch.ready drops only
// while a result waits and out_ch.ready is low.
// Reset (rst_n, synchronous) clears the entry count and the result valid; cell
// contents are left as they are, cells at or beyond the count are never read.
module sorted_array_priority_queue (
  input wire logic   clk,
  input wire logic   rst_n,
  sapq_in_if.sink    in_ch,
  sapq_out_if.source out_ch
);

  localparam int N = sapq_pkg::QUEUE_DEPTH;
  localparam int W = sapq_pkg::CNT_W;
  localparam logic [W-1:0] FULL_CNT = W'(N);

  logic [W-1:0]        count_r, count_nxt;
  logic                out_valid_r;
  sapq_pkg::entry_t    res_entry_r, res_entry_nxt;
  sapq_pkg::status_t   res_status_r, res_status_nxt;

  logic                accept;
  logic                is_full, is_empty;
  sapq_pkg::cell_ctl_t ctl;

  sapq_pkg::entry_t    entries [N];
  logic                disp    [N];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == FULL_CNT);
  assign is_empty    = (count_r == '0);

  // control: decide the cell op, the next count and the result
  always_comb begin
    ctl.op                 = sapq_pkg::OP_HOLD;
    ctl.new_entry.data     = in_ch.item_data;
    ctl.new_entry.key      = in_ch.priority_key;
    count_nxt              = count_r;
    res_entry_nxt          = res_entry_r;
    res_status_nxt         = res_status_r;
    if (accept) begin
      res_entry_nxt = '0;
      if (in_ch.command == sapq_pkg::CMD_INSERT) begin
        if (is_full) begin
          res_status_nxt = sapq_pkg::ST_FULL;
        end else begin
          ctl.op         = sapq_pkg::OP_INSERT;
          count_nxt      = count_r + W'(1);
          res_status_nxt = sapq_pkg::ST_OK;
        end
      end else if (is_empty) begin
        res_status_nxt = sapq_pkg::ST_EMPTY;
      end else begin
        ctl.op         = sapq_pkg::OP_REMOVE;
        count_nxt      = count_r - W'(1);
        res_entry_nxt  = entries[0];   // head holds the smallest key
        res_status_nxt = sapq_pkg::ST_OK;
      end
    end
  end

  // chain of cells, index 0 is the head
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [W-1:0] IDX = W'(i);
    logic             cell_valid;
    sapq_pkg::entry_t left_e;
    sapq_pkg::entry_t right_e;
    logic             left_d;

    assign cell_valid = (IDX < count_r);

    if (i == 0) begin : g_head
      assign left_e = ctl.new_entry;
      assign left_d = 1'b0;
    end else begin : g_body
      assign left_e = entries[i-1];
      assign left_d = disp[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    sapq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (cell_valid),
      .left_entry  (left_e),
      .left_disp   (left_d),
      .right_entry (right_e),
      .entry       (entries[i]),
      .disp        (disp[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_entry_r  <= res_entry_nxt;
    res_status_r <= res_status_nxt;
  end

  // occupancy follows the count, so it is taken from the register directly
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_data  = res_entry_r.data;
  assign out_ch.out_key   = res_entry_r.key;
  assign out_ch.status    = res_status_r;
  assign out_ch.occupancy = sapq_pkg::OCC_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.command == sapq_pkg::CMD_INSERT && !is_full
      |=> count_r == $past(count_r) + W'(1))
    else $error("insert did not grow the count");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.command == sapq_pkg::CMD_REMOVE && is_empty
      |=> count_r == '0 && res_status_r == sapq_pkg::ST_EMPTY)
    else $error("remove on empty mishandled");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= W'(2) |-> entries[0].key <= entries[1].key)
    else $error("head cells out of order");

endmodule

`default_nettype wire
